### hw/rtl/rrts_pkg.sv
package rrts_pkg;
  localparam int unsigned SlotsDef = 16;
  localparam int unsigned ReasonsDef = 16;

  localparam logic [2:0] StUnused  = 3'd0;
  localparam logic [2:0] StReady   = 3'd1;
  localparam logic [2:0] StRunning = 3'd2;
  localparam logic [2:0] StBlocked = 3'd3;
  localparam logic [2:0] StStopped = 3'd4;
  localparam logic [2:0] StZombie  = 3'd5;

  localparam logic [3:0] KCreate = 4'd0;
  localparam logic [3:0] KSched  = 4'd1;
  localparam logic [3:0] KBlock  = 4'd2;
  localparam logic [3:0] KWake   = 4'd3;
  localparam logic [3:0] KWakeR  = 4'd4;
  localparam logic [3:0] KTick   = 4'd5;
  localparam logic [3:0] KStop   = 4'd6;
  localparam logic [3:0] KResume = 4'd7;
  localparam logic [3:0] KExit   = 4'd8;
  localparam logic [3:0] KRelease = 4'd9;

  localparam logic [1:0] StatDone = 2'd0;
  localparam logic [1:0] StatFull = 2'd1;
  localparam logic [1:0] StatNone = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE, S_PRE, S_SCAN, S_SCHED, S_OUT
  } state_e;

  // scan flavor, chosen in the datapath from the command kind
  typedef enum logic [2:0] {
    SC_CREATE, SC_WAKER, SC_TICK, SC_SCHED
  } scan_e;

  typedef struct packed {
    logic  start;    // latch command, apply pre-scan effect
    logic  scan_en;  // advance scan one slot
    logic  sched;    // resolve schedule outcome
    logic  out_set;  // capture result
    scan_e mode;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic need_scan;
    logic need_sched;
  } sts_t;
endpackage

### hw/rtl/rrts_ctrl.sv
module rrts_ctrl
  import rrts_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  input  sts_t   sts_i,
  output cmd_t   cmd_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_PRE;
      S_PRE: begin
        if (sts_i.need_scan) state_d = S_SCAN;
        else state_d = S_OUT;
      end
      S_SCAN: begin
        if (sts_i.scan_last) state_d = sts_i.need_sched ? S_SCHED : S_OUT;
      end
      S_SCHED: state_d = S_OUT;
      S_OUT: if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.start = in_valid_i;
      end
      S_PRE: cmd_o.out_set = !sts_i.need_scan;
      S_SCAN: begin
        cmd_o.scan_en = 1'b1;
        cmd_o.out_set = sts_i.scan_last && !sts_i.need_sched;
      end
      S_SCHED: begin
        cmd_o.sched = 1'b1;
        cmd_o.out_set = 1'b1;
      end
      S_OUT: out_valid_o = 1'b1;
      default: ;
    endcase
  end
endmodule

### hw/rtl/rrts_dp.sv
module rrts_dp
  import rrts_pkg::*;
#(
  parameter int unsigned Slots = SlotsDef,
  parameter int unsigned Reasons = ReasonsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic [3:0]  kind_i,
  input  logic [3:0]  slot_i,
  input  logic [3:0]  reason_i,
  input  logic        use_timeout_i,
  input  logic [31:0] timeout_ticks_i,
  output logic [3:0]  current_slot_o,
  output logic        idle_o,
  output logic [3:0]  result_slot_o,
  output logic [1:0]  status_o
);
  localparam int unsigned SW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned RW = (Reasons > 1) ? $clog2(Reasons) : 1;

  logic [2:0]  st_q [Slots];
  logic [RW-1:0] cause_q [Slots];
  logic [63:0] wake_q [Slots];
  logic [SW-1:0] run_q;
  logic        nocur_q;
  logic [63:0] now_q;

  logic [3:0]  kind_q, reason_q;
  logic        nscan_q, nsched_q;
  logic [SW-1:0] idx_q;       // scan position
  logic [SW:0] cnt_q;         // slots scanned
  logic        found_q, any_q;
  logic [SW-1:0] pick_q;
  logic [1:0]  stat_q;
  logic [3:0]  res_q;

  logic slot_ok;
  logic [SW-1:0] slot_ix;
  logic [63:0] tk, wsum;
  scan_e mode_q;

  assign slot_ix = slot_i[SW-1:0];
  assign slot_ok = {28'd0, slot_i} < 32'(Slots);
  assign tk = (timeout_ticks_i == '0) ? 64'd1 : {32'd0, timeout_ticks_i};
  assign wsum = now_q + tk;

  assign sts_o.need_scan = nscan_q;
  assign sts_o.need_sched = nsched_q;
  assign sts_o.scan_last = (cnt_q == (SW+1)'(Slots - 1)) ||
                           (found_q && (mode_q == SC_CREATE || mode_q == SC_SCHED));

  logic [2:0] cs;
  logic [SW-1:0] nxt;
  assign cs = st_q[idx_q];
  assign nxt = (idx_q == SW'(Slots - 1)) ? '0 : idx_q + SW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Slots; i++) begin
        st_q[i] <= StUnused;
        cause_q[i] <= '0;
        wake_q[i] <= '0;
      end
      run_q <= '0; nocur_q <= 1'b1; now_q <= '0;
      nscan_q <= 1'b0; nsched_q <= 1'b0; idx_q <= '0; cnt_q <= '0;
      found_q <= 1'b0; any_q <= 1'b0; pick_q <= '0; stat_q <= StatDone;
      res_q <= '0; mode_q <= SC_SCHED;
      kind_q <= '0; reason_q <= '0;
    end else begin
      if (cmd_i.start) begin
        kind_q <= kind_i; reason_q <= reason_i;
        found_q <= 1'b0; any_q <= 1'b0; pick_q <= '0; cnt_q <= '0;
        stat_q <= StatDone; nscan_q <= 1'b0; nsched_q <= 1'b0;
        idx_q <= '0;
        case (kind_i)
          KCreate: begin nscan_q <= 1'b1; mode_q <= SC_CREATE; end
          KSched: begin
            nscan_q <= 1'b1; nsched_q <= 1'b1; mode_q <= SC_SCHED;
            idx_q <= nocur_q ? '0 : ((run_q == SW'(Slots-1)) ? '0 : run_q + SW'(1));
          end
          KBlock, KStop, KExit: begin
            if (nocur_q) stat_q <= StatNone;
            else begin
              nscan_q <= 1'b1; nsched_q <= 1'b1; mode_q <= SC_SCHED;
              idx_q <= (run_q == SW'(Slots-1)) ? '0 : run_q + SW'(1);
              if (kind_i == KBlock) begin
                st_q[run_q] <= StBlocked;
                cause_q[run_q] <= RW'(reason_i);
                wake_q[run_q] <= use_timeout_i ? wsum : 64'd0;
              end else st_q[run_q] <= (kind_i == KStop) ? StStopped : StZombie;
            end
          end
          KWake: begin
            if (slot_ok && st_q[slot_ix] == StBlocked) begin
              st_q[slot_ix] <= StReady; cause_q[slot_ix] <= '0; wake_q[slot_ix] <= '0;
            end else stat_q <= StatNone;
          end
          KWakeR: begin nscan_q <= 1'b1; mode_q <= SC_WAKER; end
          KTick: begin nscan_q <= 1'b1; mode_q <= SC_TICK; now_q <= now_q + 64'd1; end
          KResume: begin
            if (slot_ok && st_q[slot_ix] == StStopped) st_q[slot_ix] <= StReady;
            else stat_q <= StatNone;
          end
          KRelease: begin
            if (slot_ok && st_q[slot_ix] == StZombie) begin
              st_q[slot_ix] <= StUnused; cause_q[slot_ix] <= '0; wake_q[slot_ix] <= '0;
            end else stat_q <= StatNone;
          end
          default: stat_q <= StatNone;
        endcase
      end
      if (cmd_i.scan_en) begin
        idx_q <= nxt;
        cnt_q <= cnt_q + (SW+1)'(1);
        case (mode_q)
          SC_CREATE: if (!found_q && cs == StUnused) begin
            found_q <= 1'b1; pick_q <= idx_q;
            st_q[idx_q] <= StReady; cause_q[idx_q] <= '0; wake_q[idx_q] <= '0;
          end
          SC_SCHED: if (!found_q && cs == StReady) begin
            found_q <= 1'b1; pick_q <= idx_q;
          end
          SC_WAKER: if (cs == StBlocked && {{(8-RW){1'b0}}, cause_q[idx_q]} ==
                        {4'd0, reason_q}) begin
            any_q <= 1'b1;
            st_q[idx_q] <= StReady; cause_q[idx_q] <= '0; wake_q[idx_q] <= '0;
          end
          SC_TICK: if (cs == StBlocked && wake_q[idx_q] != '0 &&
                       now_q >= wake_q[idx_q]) begin
            st_q[idx_q] <= StReady; cause_q[idx_q] <= '0; wake_q[idx_q] <= '0;
          end
          default: ;
        endcase
      end
      if (cmd_i.sched) begin
        if (!found_q) begin
          if (!(nocur_q || st_q[run_q] == StRunning)) begin
            nocur_q <= 1'b1; run_q <= '0;
          end
        end else if (!(!nocur_q && pick_q == run_q && st_q[run_q] == StRunning)) begin
          if (!nocur_q && st_q[run_q] == StRunning) st_q[run_q] <= StReady;
          st_q[pick_q] <= StRunning;
          run_q <= pick_q; nocur_q <= 1'b0;
        end
      end
      if (cmd_i.out_set) begin
        // result slot (the created slot for create, else 0) and final status
        res_q <= '0;
        stat_q <= stat_q;
        if (mode_q == SC_CREATE && kind_q == KCreate) begin
          if (found_q || (cmd_i.scan_en && cs == StUnused)) begin
            res_q <= 4'(cmd_i.scan_en && !found_q ? idx_q : pick_q);
          end else stat_q <= StatFull;
        end
        if (kind_q == KWakeR && !(any_q || (cmd_i.scan_en && cs == StBlocked &&
            {{(8-RW){1'b0}}, cause_q[idx_q]} == {4'd0, reason_q}))) stat_q <= StatNone;
      end
    end
  end

  // current slot/idle read from state registers once settled
  assign current_slot_o = nocur_q ? 4'd0 : 4'(run_q);
  assign idle_o = nocur_q;
  assign result_slot_o = res_q;
  assign status_o = stat_q;
endmodule

### hw/rtl/round_robin_task_scheduler.sv
// Round-robin task table with timed sleeps. Each accepted command item
// produces exactly one result item. Commands that touch a single slot pass
// through the pre-scan state to the output state. Create, schedule, block,
// stop, exit (the last three only while a task runs), wake-by-reason and
// tick walk the slot table one slot per cycle through a shared scan unit:
// tick and wake-by-reason always walk all SLOTS slots; schedule, block, stop
// and exit add a schedule state to resolve the pick. Create, schedule, block,
// stop and exit stop walking in the cycle after the first hit. The result
// register holds until taken; the next item can be accepted in the cycle
// after that.
module round_robin_task_scheduler
  import rrts_pkg::*;
#(
  parameter int unsigned SLOTS = SlotsDef,
  parameter int unsigned REASONS = ReasonsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  kind_i,
  input  logic [3:0]  slot_i,
  input  logic [3:0]  reason_i,
  input  logic        use_timeout_i,
  input  logic [31:0] timeout_ticks_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  current_slot_o,
  output logic        idle_o,
  output logic [3:0]  result_slot_o,
  output logic [1:0]  status_o
);
  cmd_t cmd;
  sts_t sts;

  rrts_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  rrts_dp #(.Slots(SLOTS), .Reasons(REASONS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .kind_i, .slot_i, .reason_i, .use_timeout_i, .timeout_ticks_i,
    .current_slot_o, .idle_o, .result_slot_o, .status_o
  );
endmodule

### hw/rtl/rrts_chk.sv
module rrts_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [3:0] current_slot_o,
  input logic       idle_o,
  input logic [1:0] status_o
);
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while result pending");
  a_idle0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && idle_o |-> current_slot_o == 4'd0) else $error("idle slot");
  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 2'd3) else $error("bad status");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("result dropped");
endmodule

bind round_robin_task_scheduler rrts_chk u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .current_slot_o, .idle_o, .status_o
);
